// ===== src/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg: shared types and constants for the pendulum Verlet integrator
// Holds the state machine types, the register map and the CORDIC constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pvs_pkg;

    // Configuration register map
    localparam logic CFG_GRAVITY = 1'b0;
    localparam logic CFG_TSTEP   = 1'b1;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0] GRAVITY_RESET = 32'd164704584;
    localparam logic [23:0] TSTEP_RESET   = 24'd16777;

    // Angles in signed Q.30
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] CORDIC_GAIN = 64'd652032874;

    // CORDIC working widths
    localparam int ROT_W = 36;   // residual angle
    localparam int XY_W  = 34;   // vector components
    localparam int CNT_W = 5;    // iteration / reduction counter
    localparam int MB_W  = 34;   // second multiplier operand

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef enum logic [2:0] {
        SIN_IDLE,
        SIN_REDUCE,
        SIN_WRAP,
        SIN_FOLD,
        SIN_ROTATE,
        SIN_DONE
    } t_sin_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SINE,
        ST_ACCEL,
        ST_ANG1,
        ST_ANG2,
        ST_ANG3,
        ST_ANG4,
        ST_ANG5,
        ST_VEL1,
        ST_VEL2,
        ST_VEL3,
        ST_DONE
    } t_top_state;

endpackage

`default_nettype wire

// ===== src/pendulum_verlet_step.sv =====
// ----------------------------------------------------------------------------
// pendulum_verlet_step: fixed-point velocity Verlet pendulum integrator
// One transaction either loads angle and velocity or advances one step.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_ready) carries a command with
// a start angle and velocity. Command load copies them into the state and
// clears the step count; command step advances the pendulum by one time
// step. Every input transaction yields one result transaction on the output
// channel (o_out_valid / i_out_ready) with angle, velocity, count and a
// saturation flag.
// A load goes from the idle state through the done state into the output
// register. A step runs two sines on the shared CORDIC unit, then the
// sequencing states and multiply-accumulate on the one shared multiplier.
// One transaction is in work at a time; o_in_ready is high only while the
// block is idle, so a new step is not taken before the last result has
// been handed to the output register. If the receiver stalls, the finished
// result waits for the output register and the block stays busy, holding
// o_in_ready low until the output register is free.
// Reset restores the register defaults and clears the state.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none

module pendulum_verlet_step
    import pvs_pkg::*;
#(
    parameter int FRAC_BITS       = 28,
    parameter int SINE_ITERATIONS = 28
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_start_angle,
    input  wire logic signed [31:0] i_start_velocity,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_angle,
    output logic signed [31:0]      o_angular_velocity,
    output logic [31:0]             o_step_count,
    output logic                    o_saturated
);

    localparam int MA_W = (FRAC_BITS + 12 > XY_W) ? FRAC_BITS + 12 : XY_W;
    localparam int ASH  = 54 - FRAC_BITS;

    t_top_state r_state, n_state;
    logic [31:0]              r_k;
    logic [23:0]              r_dt;
    logic signed [31:0]       r_ang, n_ang, r_vel, n_vel;
    logic [31:0]              r_cnt, n_cnt;
    logic                     r_sat, n_sat, r_phase, n_phase;
    logic signed [MA_W-1:0]   r_a, n_a;
    logic signed [63:0]       r_prod, n_prod, r_acc, n_acc, r_h0, n_h0;
    logic                     r_ovalid;
    logic                     r_kick;

    logic                     w_start, w_sine_go, w_sine_done, w_load_out;
    logic signed [XY_W-1:0]   w_sine;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [MA_W+MB_W-1:0] w_mul;
    logic signed [63:0]       w_sh24, w_neg, w_asr, w_accsh;
    logic signed [31:0]       w_clamp;
    logic                     w_hi, w_lo;

    pvs_sine #(
        .FRAC_BITS       (FRAC_BITS),
        .SINE_ITERATIONS (SINE_ITERATIONS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sine_go),
        .i_angle (r_ang),
        .o_done  (w_sine_done),
        .o_sine  (w_sine)
    );

    // Shared multiplier and the fixed shifts around it
    assign w_mul  = w_ma * w_mb;
    assign w_sh24 = r_prod >>> 24;
    assign w_neg  = -r_prod;
    assign w_asr  = w_neg >>> ASH;
    assign w_accsh = r_acc >>> 24;
    assign w_hi   = (w_accsh > 64'sd2147483647);
    assign w_lo   = (w_accsh < -64'sd2147483648);
    assign w_clamp = w_hi ? 32'sh7fffffff : (w_lo ? 32'sh80000000 : w_accsh[31:0]);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_load_out = (r_state == ST_DONE) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= GRAVITY_RESET;
            r_dt     <= TSTEP_RESET;
            r_ang    <= '0;
            r_vel    <= '0;
            r_cnt    <= '0;
            r_sat    <= 1'b0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ang   <= n_ang;
            r_vel   <= n_vel;
            r_cnt   <= n_cnt;
            r_sat   <= n_sat;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRAVITY: r_k  <= i_cfg_data;
                    CFG_TSTEP:   r_dt <= i_cfg_data[23:0];
                    default:     r_k  <= r_k;
                endcase
            end
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_a    <= n_a;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_h0   <= n_h0;
        if (w_load_out) begin
            o_angle            <= r_ang;
            o_angular_velocity <= r_vel;
            o_step_count       <= r_cnt;
            o_saturated        <= r_sat;
        end
    end

    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        n_ang   = r_ang;
        n_vel   = r_vel;
        n_cnt   = r_cnt;
        n_sat   = r_sat;
        n_phase = r_phase;
        n_a     = r_a;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_h0    = r_h0;
        w_start = 1'b0;
        w_ma    = MA_W'(r_vel);
        w_mb    = $signed({10'b0, r_dt});
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sat = 1'b0;
                    if (i_command == CMD_LOAD) begin
                        n_ang   = i_start_angle;
                        n_vel   = i_start_velocity;
                        n_cnt   = '0;
                        n_state = ST_DONE;
                    end else begin
                        w_start = 1'b1;
                        n_phase = 1'b0;
                        n_state = ST_SINE;
                    end
                end
            end
            ST_SINE: begin
                w_ma = MA_W'(w_sine);
                w_mb = $signed({2'b00, r_k});
                if (w_sine_done) begin
                    n_prod  = w_mul[63:0];
                    n_state = ST_ACCEL;
                end
            end
            ST_ACCEL: begin
                n_a = w_asr[MA_W-1:0];
                // The rounding half is placed below the shifted state word.
                if (!r_phase) begin
                    n_acc   = {{8{r_ang[31]}}, r_ang, 24'h800000};
                    n_state = ST_ANG1;
                end else begin
                    n_acc   = $signed({{8{r_vel[31]}}, r_vel, 24'h800000}) + r_h0;
                    n_state = ST_VEL1;
                end
            end
            ST_ANG1: begin
                w_ma    = MA_W'(r_vel);
                n_prod  = w_mul[63:0];
                n_state = ST_ANG2;
            end
            ST_ANG2: begin
                w_ma    = r_a;
                n_acc   = r_acc + r_prod;
                n_prod  = w_mul[63:0];
                n_state = ST_ANG3;
            end
            ST_ANG3: begin
                // Keep half of a0*dt for the velocity update.
                w_ma    = w_sh24[MA_W-1:0];
                n_h0    = r_prod >>> 1;
                n_prod  = w_mul[63:0];
                n_state = ST_ANG4;
            end
            ST_ANG4: begin
                n_acc   = r_acc + (r_prod >>> 1);
                n_state = ST_ANG5;
            end
            ST_ANG5: begin
                n_ang   = w_clamp;
                n_sat   = r_sat | w_hi | w_lo;
                n_phase = 1'b1;
                n_state = ST_SINE;
            end
            ST_VEL1: begin
                w_ma    = r_a;
                n_prod  = w_mul[63:0];
                n_state = ST_VEL2;
            end
            ST_VEL2: begin
                n_acc   = r_acc + (r_prod >>> 1);
                n_state = ST_VEL3;
            end
            ST_VEL3: begin
                n_vel   = w_clamp;
                n_sat   = r_sat | w_hi | w_lo;
                n_cnt   = r_cnt + 32'd1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Kick the second sine in the cycle after the new angle is stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= 1'b0;
        end else begin
            r_kick <= (r_state == ST_ANG5);
        end
    end

    assign w_sine_go = w_start | r_kick;

    a_sine_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sine_done |-> (r_state == ST_SINE))
        else $error("sine unit finished outside a wait state");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_command == CMD_LOAD)) |=>
            ((r_cnt == 32'd0) && !r_sat))
        else $error("load did not clear count and flag");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            ((o_angle == 32'sh7fffffff) || (o_angle == 32'sh80000000) ||
             (o_angular_velocity == 32'sh7fffffff) ||
             (o_angular_velocity == 32'sh80000000)))
        else $error("saturation flagged without a clamped value");

endmodule

`default_nettype wire

// ===== src/pvs_sine.sv =====
// ----------------------------------------------------------------------------
// pvs_sine: iterative sine unit
// Reduces the angle modulo two pi by restoring subtraction, folds it into
// the right half plane, then runs a rotation-mode CORDIC one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_sine
    import pvs_pkg::*;
#(
    parameter int FRAC_BITS       = 28,
    parameter int SINE_ITERATIONS = 28
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [31:0]      i_angle,
    output logic                         o_done,
    output logic signed [XY_W-1:0]       o_sine
);

    localparam int RW     = 64 - FRAC_BITS;
    localparam int SH     = 30 - FRAC_BITS;
    localparam int RSTEPS = RW - 32;

    localparam logic [RW-1:0] DIV_INIT = RW'(Q30_TWO_PI << (RSTEPS - 1));
    localparam logic signed [ROT_W-1:0] PI_R   = ROT_W'(Q30_PI);
    localparam logic signed [ROT_W-1:0] TPI_R  = ROT_W'(Q30_TWO_PI);
    localparam logic signed [ROT_W-1:0] HPI_R  = ROT_W'(Q30_HALF_PI);
    localparam logic signed [XY_W-1:0]  GAIN_X = XY_W'(CORDIC_GAIN);

    t_sin_state r_state, n_state;
    logic [RW-1:0]              r_m, n_m, r_div, n_div;
    logic                       r_sgn, n_sgn;
    logic signed [ROT_W-1:0]    r_r, n_r;
    logic signed [XY_W-1:0]     r_x, n_x, r_y, n_y;
    logic [CNT_W-1:0]           r_cnt, n_cnt;

    logic signed [RW-1:0]       w_ang_ext;
    logic signed [ROT_W-1:0]    w_m, w_d, w_at;
    logic signed [XY_W-1:0]     w_xs, w_ys;

    assign w_ang_ext = $signed({{(RW - 32){i_angle[31]}}, i_angle}) <<< SH;
    assign w_m       = $signed({2'b00, r_m[33:0]});
    assign w_d       = w_m - TPI_R;
    assign w_at      = $signed({6'b000000, ATAN_Q30[r_cnt]});
    assign w_xs      = r_x >>> r_cnt;
    assign w_ys      = r_y >>> r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIN_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_m   <= n_m;
        r_div <= n_div;
        r_sgn <= n_sgn;
        r_r   <= n_r;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_div   = r_div;
        n_sgn   = r_sgn;
        n_r     = r_r;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        case (r_state)
            SIN_IDLE: begin
                if (i_start) begin
                    n_sgn   = i_angle[31];
                    n_m     = i_angle[31] ? RW'(-w_ang_ext) : RW'(w_ang_ext);
                    n_div   = DIV_INIT;
                    n_cnt   = '0;
                    n_state = SIN_REDUCE;
                end
            end
            SIN_REDUCE: begin
                // Remainder keeps the sign of the dividend, so work on the magnitude.
                if (r_m >= r_div) begin
                    n_m = r_m - r_div;
                end
                n_div = r_div >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RSTEPS - 1)) begin
                    n_state = SIN_WRAP;
                end
            end
            SIN_WRAP: begin
                if (w_m > PI_R) begin
                    n_r = r_sgn ? -w_d : w_d;
                end else begin
                    n_r = r_sgn ? -w_m : w_m;
                end
                n_state = SIN_FOLD;
            end
            SIN_FOLD: begin
                if (r_r > HPI_R) begin
                    n_r = PI_R - r_r;
                end else if (r_r < -HPI_R) begin
                    n_r = -PI_R - r_r;
                end
                n_x     = GAIN_X;
                n_y     = '0;
                n_cnt   = '0;
                n_state = SIN_ROTATE;
            end
            SIN_ROTATE: begin
                if (!r_r[ROT_W-1]) begin
                    n_x = r_x - w_ys;
                    n_y = r_y + w_xs;
                    n_r = r_r - w_at;
                end else begin
                    n_x = r_x + w_ys;
                    n_y = r_y - w_xs;
                    n_r = r_r + w_at;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SINE_ITERATIONS - 1)) begin
                    n_state = SIN_DONE;
                end
            end
            SIN_DONE: begin
                n_state = SIN_IDLE;
            end
            default: begin
                n_state = SIN_IDLE;
            end
        endcase
    end

    assign o_done = (r_state == SIN_DONE);
    assign o_sine = r_y;

endmodule

`default_nettype wire
